// ===== design/mrm_pkg.sv =====
// Shared types and constants for the Miller-Rabin Montgomery test block.
// Used by the top level, the Montgomery multiplier and the port checker.
`default_nettype none

package mrm_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int LIMB_BITS     = 32;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BASE  = 2'd1;
    localparam logic [1:0] ERR_SMALL = 2'd2;

    typedef struct packed {
        logic [63:0] candidate;
        logic [63:0] witness_base;
        logic        last_base;
    } t_in_word;

    typedef struct packed {
        logic       probable_prime;
        logic [1:0] error_code;
    } t_out_word;

endpackage

`default_nettype wire

// ===== design/mrm_mont.sv =====
// Iterative Montgomery multiplier, R = 2^64, on one 32x32 multiplier.
// Depends on mrm_pkg for the limb width.
`default_nettype none

module mrm_mont (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_n,
    input  logic [63:0] i_npi,
    output logic        o_done,
    output logic [63:0] o_res
);

    localparam int LB = mrm_pkg::LIMB_BITS;

    logic [63:0]  r_a, r_b, r_n, r_npi, r_m, r_res;
    logic [127:0] r_t, r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic         r_ppv, r_busy, r_done;
    logic [4:0]   r_cnt;

    logic [LB-1:0] mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [1:0]    mul_sh;
    logic          mul_issue;

    logic [63:0] th, tl, mh, ml, u, fin;
    logic [64:0] low_sum;

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_sh    = 2'd0;
        mul_issue = 1'b0;
        case (r_cnt)
            5'd0: begin
                mul_a = r_a[31:0];  mul_b = r_b[31:0];  mul_issue = 1'b1;
            end
            5'd1: begin
                mul_a = r_a[31:0];  mul_b = r_b[63:32]; mul_sh = 2'd1; mul_issue = 1'b1;
            end
            5'd2: begin
                mul_a = r_a[63:32]; mul_b = r_b[31:0];  mul_sh = 2'd1; mul_issue = 1'b1;
            end
            5'd3: begin
                mul_a = r_a[63:32]; mul_b = r_b[63:32]; mul_sh = 2'd2; mul_issue = 1'b1;
            end
            5'd6: begin
                mul_a = r_t[31:0];  mul_b = r_npi[31:0];  mul_issue = 1'b1;
            end
            5'd7: begin
                mul_a = r_t[31:0];  mul_b = r_npi[63:32]; mul_sh = 2'd1; mul_issue = 1'b1;
            end
            5'd8: begin
                mul_a = r_t[63:32]; mul_b = r_npi[31:0];  mul_sh = 2'd1; mul_issue = 1'b1;
            end
            5'd11: begin
                mul_a = r_m[31:0];  mul_b = r_n[31:0];  mul_issue = 1'b1;
            end
            5'd12: begin
                mul_a = r_m[31:0];  mul_b = r_n[63:32]; mul_sh = 2'd1; mul_issue = 1'b1;
            end
            5'd13: begin
                mul_a = r_m[63:32]; mul_b = r_n[31:0];  mul_sh = 2'd1; mul_issue = 1'b1;
            end
            5'd14: begin
                mul_a = r_m[63:32]; mul_b = r_n[63:32]; mul_sh = 2'd2; mul_issue = 1'b1;
            end
            default: begin
                mul_issue = 1'b0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    assign th      = r_t[127:64];
    assign tl      = r_t[63:0];
    assign mh      = r_acc[127:64];
    assign ml      = r_acc[63:0];
    assign low_sum = {1'b0, tl} + {1'b0, ml};
    assign u       = th + mh + {63'd0, low_sum[64]};
    assign fin     = ((u < th) || (u >= r_n)) ? u - r_n : u;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_n    <= i_n;
            r_npi  <= i_npi;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_ppv  <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_pp  <= mul_p;
            r_sh  <= mul_sh;
            r_ppv <= mul_issue;
            if (r_ppv) begin
                r_acc <= r_acc + ({64'd0, r_pp} << {r_sh, 5'd0});
            end
            if (r_cnt == 5'd5) begin
                r_t   <= r_acc;
                r_acc <= '0;
            end
            if (r_cnt == 5'd10) begin
                r_m   <= r_acc[63:0];
                r_acc <= '0;
            end
            if (r_cnt == 5'd16) begin
                r_res  <= fin;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            r_cnt  <= '0;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== design/miller_rabin_montgomery_test.sv =====
// Top level: strong probable-prime test sequencer around a shared Montgomery unit.
// Depends on mrm_pkg and mrm_mont.
`default_nettype none

// One base takes one word at a time: the special cases finish early, and
// otherwise the block computes the Montgomery inverse, then R mod n, then the
// power-of-two split, then maps the base, then runs the Montgomery products (up
// to about 125 of them) for a full 64-bit candidate. Each product runs its
// partial products in turn on the single 32x32 multiplier in the Montgomery
// unit. The input stalls from accept until the word is done; a result word is
// produced only for the word marked last_base.

module miller_rabin_montgomery_test #(
    parameter int WORD_BITS = mrm_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mrm_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mrm_pkg::t_out_word o_out_word
);

    localparam logic [63:0] WordMask = {64{1'b1}} >> (64 - WORD_BITS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_NINV    = 4'd2;
    localparam logic [3:0] S_ONE     = 4'd3;
    localparam logic [3:0] S_TZ      = 4'd4;
    localparam logic [3:0] S_XMUL    = 4'd5;
    localparam logic [3:0] S_XCHK    = 4'd6;
    localparam logic [3:0] S_EXP_D   = 4'd7;
    localparam logic [3:0] S_WAIT_D  = 4'd8;
    localparam logic [3:0] S_EXP_X   = 4'd9;
    localparam logic [3:0] S_WAIT_X  = 4'd10;
    localparam logic [3:0] S_CHKD    = 4'd11;
    localparam logic [3:0] S_SQ      = 4'd12;
    localparam logic [3:0] S_WAIT_SQ = 4'd13;
    localparam logic [3:0] S_FINISH  = 4'd14;

    logic [3:0]  r_state;
    logic [63:0] r_n, r_a, r_npi, r_s, r_one, r_u, r_x, r_d;
    logic        r_last, r_item_comp, r_comp_seen, r_phase, r_out_valid;
    logic [1:0]  r_item_err, r_err_seen;
    logic [6:0]  r_t, r_cnt;
    logic [5:0]  r_idx;
    mrm_pkg::t_out_word r_out_word;

    logic [63:0] am_x, am_y, am_ny, am_r;
    logic [63:0] h1, q, q1, tab, minus_one;
    logic [1:0]  idx, dig;
    logic        bit1;
    logic        mont_start, mont_done;
    logic [63:0] mont_a, mont_b, mont_res;
    logic        fin_comp;
    logic [1:0]  fin_err;

    assign am_ny = r_n - am_y;
    assign am_r  = (am_x >= am_ny) ? am_x - am_ny : am_x + am_y;

    always_comb begin
        am_x = r_x;
        am_y = r_x;
        case (r_state)
            S_ONE: begin
                am_x = r_one;
                am_y = r_one;
            end
            S_XMUL: begin
                am_x = r_x;
                am_y = r_phase ? r_one : r_x;
            end
            default: begin
                am_x = r_x;
                am_y = r_x;
            end
        endcase
    end

    assign h1   = (r_n >> 1) + 64'd1;
    assign q    = r_n >> 2;
    assign q1   = q + 64'd1;
    assign bit1 = r_n[1];
    assign idx  = r_s[1:0];
    assign dig  = bit1 ? idx : 2'b00 - idx;

    always_comb begin
        case (idx)
            2'd0:    tab = 64'd0;
            2'd1:    tab = bit1 ? q1 : h1 + q;
            2'd2:    tab = h1;
            2'd3:    tab = bit1 ? h1 + q1 : q1;
            default: tab = 64'd0;
        endcase
    end

    assign minus_one = r_n - r_one;

    always_comb begin
        mont_start = 1'b0;
        mont_a     = r_d;
        mont_b     = r_d;
        case (r_state)
            S_EXP_D: begin
                mont_start = r_u[0];
                mont_a     = r_d;
                mont_b     = r_x;
            end
            S_EXP_X: begin
                mont_start = (r_u[63:1] != 63'd0);
                mont_a     = r_x;
                mont_b     = r_x;
            end
            S_SQ: begin
                mont_start = 1'b1;
            end
            default: begin
                mont_start = 1'b0;
            end
        endcase
    end

    mrm_mont u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mont_start),
        .i_a     (mont_a),
        .i_b     (mont_b),
        .i_n     (r_n),
        .i_npi   (r_npi),
        .o_done  (mont_done),
        .o_res   (mont_res)
    );

    assign fin_comp = r_comp_seen | r_item_comp;
    assign fin_err  = (r_err_seen == mrm_pkg::ERR_NONE) ? r_item_err : r_err_seen;

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_n     <= i_in_word.candidate & WordMask;
                    r_a     <= i_in_word.witness_base & WordMask;
                    r_last  <= i_in_word.last_base;
                    r_state <= S_CHECK;
                end
            end
            S_CHECK: begin
                r_item_err  <= mrm_pkg::ERR_NONE;
                r_item_comp <= 1'b0;
                r_s         <= 64'd1;
                r_npi       <= '0;
                r_cnt       <= '0;
                if (r_n <= 64'd3) begin
                    r_item_err <= mrm_pkg::ERR_SMALL;
                    r_state    <= S_FINISH;
                end else if (!r_n[0]) begin
                    r_item_comp <= 1'b1;
                    r_state     <= S_FINISH;
                end else if (r_a < 64'd2) begin
                    r_item_err <= mrm_pkg::ERR_BASE;
                    r_state    <= S_FINISH;
                end else begin
                    r_state <= S_NINV;
                end
            end
            S_NINV: begin
                r_npi <= {dig, r_npi[63:2]};
                r_s   <= (r_s >> 2) + tab;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd31) begin
                    r_one   <= 64'd1;
                    r_cnt   <= '0;
                    r_state <= S_ONE;
                end
            end
            S_ONE: begin
                r_one <= am_r;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_u     <= r_n - 64'd1;
                    r_t     <= '0;
                    r_state <= S_TZ;
                end
            end
            S_TZ: begin
                if (!r_u[0] && (r_t < 7'd64)) begin
                    r_u <= r_u >> 1;
                    r_t <= r_t + 7'd1;
                end else begin
                    r_x     <= '0;
                    r_idx   <= 6'd63;
                    r_phase <= 1'b0;
                    r_state <= S_XMUL;
                end
            end
            S_XMUL: begin
                if (!r_phase) begin
                    r_x     <= am_r;
                    r_phase <= 1'b1;
                end else begin
                    if (r_a[r_idx]) begin
                        r_x <= am_r;
                    end
                    r_phase <= 1'b0;
                    if (r_idx == 6'd0) begin
                        r_state <= S_XCHK;
                    end else begin
                        r_idx <= r_idx - 6'd1;
                    end
                end
            end
            S_XCHK: begin
                r_d <= r_one;
                r_state <= (r_x == 64'd0) ? S_FINISH : S_EXP_D;
            end
            S_EXP_D: begin
                r_state <= r_u[0] ? S_WAIT_D : S_EXP_X;
            end
            S_WAIT_D: begin
                if (mont_done) begin
                    r_d     <= mont_res;
                    r_state <= S_EXP_X;
                end
            end
            S_EXP_X: begin
                r_u     <= r_u >> 1;
                r_state <= (r_u[63:1] != 63'd0) ? S_WAIT_X : S_CHKD;
            end
            S_WAIT_X: begin
                if (mont_done) begin
                    r_x     <= mont_res;
                    r_state <= S_EXP_D;
                end
            end
            S_CHKD: begin
                r_cnt <= 7'd1;
                if ((r_d == r_one) || (r_d == minus_one)) begin
                    r_state <= S_FINISH;
                end else if (r_t > 7'd1) begin
                    r_state <= S_SQ;
                end else begin
                    r_item_comp <= 1'b1;
                    r_state     <= S_FINISH;
                end
            end
            S_SQ: begin
                r_state <= S_WAIT_SQ;
            end
            S_WAIT_SQ: begin
                if (mont_done) begin
                    r_d <= mont_res;
                    if (mont_res == r_one) begin
                        r_item_comp <= 1'b1;
                        r_state     <= S_FINISH;
                    end else if (mont_res == minus_one) begin
                        r_state <= S_FINISH;
                    end else if ((r_cnt + 7'd1) < r_t) begin
                        r_cnt   <= r_cnt + 7'd1;
                        r_state <= S_SQ;
                    end else begin
                        r_item_comp <= 1'b1;
                        r_state     <= S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_last) begin
                    r_comp_seen <= fin_comp;
                    r_err_seen  <= fin_err;
                    r_state     <= S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    r_out_word.probable_prime <= !fin_comp && (fin_err == mrm_pkg::ERR_NONE);
                    r_out_word.error_code     <= fin_err;
                    r_out_valid <= 1'b1;
                    r_comp_seen <= 1'b0;
                    r_err_seen  <= mrm_pkg::ERR_NONE;
                    r_state     <= S_IDLE;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_comp_seen <= 1'b0;
            r_err_seen  <= mrm_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== design/mrm_checker.sv =====
// Port-level checker for miller_rabin_montgomery_test, attached by bind.
// Depends on mrm_pkg for the word types and error codes.
`default_nettype none

module mrm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mrm_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mrm_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    a_error_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.error_code != mrm_pkg::ERR_NONE)
            |-> !o_out_word.probable_prime)
        else $error("probable prime flagged with an error");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind miller_rabin_montgomery_test mrm_checker u_mrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
